### hw/rtl/qsr_pkg.sv
// ----------------------------------------------------------------------------
// Quadrature speed regulator package
// Shared types and constants for the decoder front end, the item queue and
// the regulation back end.
// ----------------------------------------------------------------------------
package qsr_pkg;

    // Field widths fixed by the interface.
    localparam int DUTY_W      = 16;
    localparam int POS_W       = 9;
    localparam int PHASE_W     = 3;
    localparam int REV_W       = 2;
    localparam int ELAPSED_W   = 16;
    localparam int TARGET_W    = 16;
    localparam int CPR_W       = 8;

    // Stream data widths, padded to whole bytes.
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 48;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_MS      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DUTY_MAX       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DUTY_INITIAL   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNTS_PER_REV = 2'd3;

    // Reset values of the configuration registers and of the duty.
    localparam logic [TARGET_W-1:0]    TARGET_RST       = 16'd100;
    localparam logic [DUTY_W-1:0]      DUTY_MAX_RST     = 16'd1000;
    localparam logic [DUTY_W-1:0]      DUTY_INITIAL_RST = 16'd500;
    localparam logic [CPR_W-1:0]       CPR_RST          = 8'd48;

    // Kind of an input word.
    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_TICK   = 1'b1
    } kind_t;

    // Decoder states.
    typedef enum logic [PHASE_W-1:0] {
        PH_RESET = 3'd0,
        PH_A0B0  = 3'd1,
        PH_A0B1  = 3'd2,
        PH_A1B0  = 3'd3,
        PH_A1B1  = 3'd4
    } phase_t;

    // Revolution flags.
    typedef enum logic [REV_W-1:0] {
        REV_NONE = 2'd0,
        REV_CW   = 2'd1,
        REV_CCW  = 2'd2
    } rev_t;

    // One classified item in the queue.
    typedef struct packed {
        kind_t kind;
        logic  reset_request;
        logic  chan_a;
        logic  chan_b;
    } item_t;

    // Queue head handed from front to back.
    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    // Configuration seen by the back end.
    typedef struct packed {
        logic [TARGET_W-1:0]    target_ms;
        logic [DUTY_W-1:0]      duty_max;
        logic [CPR_W-1:0]       counts_per_rev;
    } cfg_t;

endpackage

### hw/rtl/qsr_front.sv
// ----------------------------------------------------------------------------
// Quadrature speed regulator front end
// Accepts input words, classifies them into items and holds them in a short
// queue until the back end takes them.
// ----------------------------------------------------------------------------
module qsr_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [qsr_pkg::S_DATA_W-1:0]  s_tdata,   // reset_request, chan_a, chan_b
    input  logic                          s_tuser,   // action
    output qsr_pkg::head_t                head,
    input  logic                          pop
);

    localparam int PTR_W = $clog2(qsr_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(qsr_pkg::QUEUE_DEPTH + 1);

    qsr_pkg::item_t   queue_reg [qsr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    qsr_pkg::item_t   item_in;
    logic             push;

    // Classify the incoming word.
    always_comb
    begin
        item_in.kind          = s_tuser ? qsr_pkg::KIND_TICK : qsr_pkg::KIND_SAMPLE;
        item_in.reset_request = s_tdata[0];
        item_in.chan_a        = s_tdata[1];
        item_in.chan_b        = s_tdata[2];
    end

    assign s_tready = (count_reg != CNT_W'(qsr_pkg::QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;

    // Queue pointers and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(qsr_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(qsr_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= item_in;
        end
    end

    // Head of the queue for the back end.
    assign head.valid = (count_reg != '0);
    assign head.item  = queue_reg[rd_ptr_reg];

endmodule

### hw/rtl/qsr_back.sv
// ----------------------------------------------------------------------------
// Quadrature speed regulator back end
// Runs the quadrature state machine, the position count, the millisecond
// timer and the duty regulation, and holds each result in an output register.
// ----------------------------------------------------------------------------
module qsr_back
#(
    parameter int TIMER_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  qsr_pkg::head_t                head,
    output logic                          pop,
    input  qsr_pkg::cfg_t                 cfg,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [qsr_pkg::M_DATA_W-1:0]  m_tdata
);

    localparam int CMP_W = (TIMER_WIDTH > qsr_pkg::ELAPSED_W) ? TIMER_WIDTH :
                           qsr_pkg::ELAPSED_W;
    localparam int SUM_W = qsr_pkg::POS_W + 1;
    localparam int PAD_W = qsr_pkg::M_DATA_W - qsr_pkg::DUTY_W - qsr_pkg::POS_W -
                           qsr_pkg::PHASE_W - qsr_pkg::REV_W - qsr_pkg::ELAPSED_W;

    qsr_pkg::phase_t                  state_reg, state_next;
    logic signed [qsr_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [TIMER_WIDTH-1:0]           timer_reg, timer_next;
    logic [qsr_pkg::DUTY_W-1:0]       duty_reg, duty_next;
    logic                             out_valid_reg;
    logic [qsr_pkg::M_DATA_W-1:0]     out_data_reg;

    qsr_pkg::phase_t                  phase_target;
    qsr_pkg::phase_t                  decode_next;
    logic                             in_phase;
    logic                             step_up;
    logic                             step_down;
    logic signed [SUM_W-1:0]          pos_sum;
    logic signed [SUM_W-1:0]          pos_clamped;
    logic signed [SUM_W-1:0]          cpr_pos;
    qsr_pkg::rev_t                    rev;
    logic [CMP_W-1:0]                 timer_cmp;
    logic [CMP_W-1:0]                 target_cmp;
    logic [qsr_pkg::ELAPSED_W-1:0]    elapsed;

    // Take an item whenever the output register is free or being emptied.
    assign pop = head.valid && (!out_valid_reg || m_tready);

    // Phase that matches the channel levels.
    always_comb
    begin
        unique case ({head.item.chan_a, head.item.chan_b})
            2'b00:   phase_target = qsr_pkg::PH_A0B0;
            2'b01:   phase_target = qsr_pkg::PH_A0B1;
            2'b10:   phase_target = qsr_pkg::PH_A1B0;
            default: phase_target = qsr_pkg::PH_A1B1;
        endcase
    end

    // Decoder next state; if both change, A leads from A0 phases, B from A1.
    always_comb
    begin
        decode_next = state_reg;
        unique case (state_reg)
            qsr_pkg::PH_A0B0:
            begin
                if (head.item.chan_a)       decode_next = qsr_pkg::PH_A1B0;
                else if (head.item.chan_b)  decode_next = qsr_pkg::PH_A0B1;
            end
            qsr_pkg::PH_A0B1:
            begin
                if (head.item.chan_a)       decode_next = qsr_pkg::PH_A1B1;
                else if (!head.item.chan_b) decode_next = qsr_pkg::PH_A0B0;
            end
            qsr_pkg::PH_A1B0:
            begin
                if (head.item.chan_b)       decode_next = qsr_pkg::PH_A1B1;
                else if (!head.item.chan_a) decode_next = qsr_pkg::PH_A0B0;
            end
            qsr_pkg::PH_A1B1:
            begin
                if (!head.item.chan_b)      decode_next = qsr_pkg::PH_A1B0;
                else if (!head.item.chan_a) decode_next = qsr_pkg::PH_A0B1;
            end
            default:
            begin
                decode_next = phase_target;
            end
        endcase
    end

    // Decoder outputs: count direction for the move.
    always_comb
    begin
        in_phase  = 1'b1;
        step_up   = 1'b0;
        step_down = 1'b0;
        unique case (state_reg)
            qsr_pkg::PH_A0B0:
            begin
                step_up   = head.item.chan_a;
                step_down = !head.item.chan_a && head.item.chan_b;
            end
            qsr_pkg::PH_A0B1:
            begin
                step_down = head.item.chan_a;
                step_up   = !head.item.chan_a && !head.item.chan_b;
            end
            qsr_pkg::PH_A1B0:
            begin
                step_up   = head.item.chan_b;
                step_down = !head.item.chan_b && !head.item.chan_a;
            end
            qsr_pkg::PH_A1B1:
            begin
                step_down = !head.item.chan_b;
                step_up   = head.item.chan_b && !head.item.chan_a;
            end
            default:
            begin
                in_phase = 1'b0;
            end
        endcase
    end

    // Position step with saturation at plus and minus 255.
    always_comb
    begin
        pos_sum = SUM_W'(pos_reg);
        if (step_up)
        begin
            pos_sum = SUM_W'(pos_reg) + SUM_W'(1);
        end
        else if (step_down)
        begin
            pos_sum = SUM_W'(pos_reg) - SUM_W'(1);
        end
        pos_clamped = pos_sum;
        if (pos_sum > SUM_W'(255))
        begin
            pos_clamped = SUM_W'(255);
        end
        else if (pos_sum < -SUM_W'(255))
        begin
            pos_clamped = -SUM_W'(255);
        end
    end

    assign cpr_pos    = SUM_W'(cfg.counts_per_rev);
    assign timer_cmp  = CMP_W'(timer_reg);
    assign target_cmp = CMP_W'(cfg.target_ms);

    // State update for the item at the head of the queue.
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        timer_next = timer_reg;
        duty_next  = duty_reg;
        rev        = qsr_pkg::REV_NONE;
        if (head.item.kind == qsr_pkg::KIND_TICK)
        begin
            if (timer_reg != {TIMER_WIDTH{1'b1}})
            begin
                timer_next = timer_reg + 1'b1;
            end
        end
        else
        begin
            if (!in_phase)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_clamped[qsr_pkg::POS_W-1:0];
                if (pos_clamped == cpr_pos)
                begin
                    rev = qsr_pkg::REV_CW;
                end
                else if (pos_clamped == -cpr_pos)
                begin
                    rev = qsr_pkg::REV_CCW;
                end
                if (rev != qsr_pkg::REV_NONE)
                begin
                    // Bang-bang duty step against the set point.
                    if (timer_cmp > target_cmp)
                    begin
                        if (duty_reg < cfg.duty_max)
                        begin
                            duty_next = duty_reg + 1'b1;
                        end
                    end
                    else if (timer_cmp < target_cmp)
                    begin
                        if (duty_reg != '0)
                        begin
                            duty_next = duty_reg - 1'b1;
                        end
                    end
                    pos_next   = '0;
                    timer_next = '0;
                end
            end
            state_next = head.item.reset_request ? qsr_pkg::PH_RESET : decode_next;
        end
    end

    // Reported timer, saturated to the field width.
    always_comb
    begin
        if (CMP_W'(timer_next) > CMP_W'({qsr_pkg::ELAPSED_W{1'b1}}))
        begin
            elapsed = {qsr_pkg::ELAPSED_W{1'b1}};
        end
        else
        begin
            elapsed = qsr_pkg::ELAPSED_W'(timer_next);
        end
    end

    // Regulator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qsr_pkg::PH_RESET;
            pos_reg   <= '0;
            timer_reg <= '0;
            duty_reg  <= qsr_pkg::DUTY_INITIAL_RST;
        end
        else if (pop)
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            timer_reg <= timer_next;
            duty_reg  <= duty_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output word payload.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= {{PAD_W{1'b0}}, elapsed, rev, state_next, pos_next,
                             duty_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### hw/rtl/quadrature_speed_regulator.sv
// ----------------------------------------------------------------------------
// Quadrature speed regulator
// Quadrature encoder decoder with bang-bang PWM duty regulation per revolution.
// ----------------------------------------------------------------------------
// An accepted word is held in the queue, then its result in the output register on m_tdata.
// One word per cycle while m_tready is high; the back end retires one queued item a cycle.
// A two-entry queue and the output register let either side stall on its own.
// Reset clears the queue and output, sets the decoder to its reset state,
// clears count and timer, loads duty 500 and the default configuration.
module quadrature_speed_regulator
#(
    parameter int TIMER_WIDTH = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [qsr_pkg::S_DATA_W-1:0]      s_tdata,  // reset_request, chan_a, chan_b, zeros
    input  logic                              s_tuser,  // action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [qsr_pkg::M_DATA_W-1:0]      m_tdata,  // duty, position_count, phase_state,
                                                        // revolution, elapsed_ms, zeros
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [qsr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [qsr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [qsr_pkg::TARGET_W-1:0]    target_reg;
    logic [qsr_pkg::DUTY_W-1:0]      duty_max_reg;
    logic [qsr_pkg::CPR_W-1:0]       cpr_reg;
    qsr_pkg::cfg_t                   cfg;
    qsr_pkg::head_t                  head;
    logic                            pop;

    assign cfg_ready = 1'b1;

    // Configuration registers. The initial duty only matters at reset, so a
    // write to it is taken and has no further effect.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= qsr_pkg::TARGET_RST;
            duty_max_reg  <= qsr_pkg::DUTY_MAX_RST;
            cpr_reg       <= qsr_pkg::CPR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                qsr_pkg::CFG_TARGET_MS:      target_reg    <= cfg_data;
                qsr_pkg::CFG_DUTY_MAX:       duty_max_reg  <= cfg_data;
                qsr_pkg::CFG_COUNTS_PER_REV: cpr_reg       <= cfg_data[qsr_pkg::CPR_W-1:0];
                default:                     ;
            endcase
        end
    end

    assign cfg.target_ms      = target_reg;
    assign cfg.duty_max       = duty_max_reg;
    assign cfg.counts_per_rev = cpr_reg;

    // Front end: accept and queue words.
    qsr_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .head     (head),
        .pop      (pop)
    );

    // Back end: decode, count, regulate and register the result.
    qsr_back
    #(
        .TIMER_WIDTH (TIMER_WIDTH)
    )
    u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .cfg      (cfg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
